// ===== hdl/stop_and_wait_packet_receiver_assert.svh =====
// Assertion macros shared by the receiver RTL.
`ifndef STOP_AND_WAIT_PACKET_RECEIVER_ASSERT_SVH
`define STOP_AND_WAIT_PACKET_RECEIVER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SWPR_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define SWPR_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/swpr_pkg.sv =====
// Types, constants and the checksum fold shared by the receiver RTL.
package swpr_pkg;

  localparam int unsigned POS_W       = 11;
  localparam int unsigned MAX_PACKET  = 1500;
  localparam int unsigned HEADER_SIZE = 14;
  localparam int unsigned FLAG_POS    = 8;
  localparam int unsigned SEQ_BYTES   = 4;
  localparam int unsigned CFG_ADDR_W  = 3;

  localparam logic [POS_W-1:0] POS_LIMIT = '1;
  localparam logic [7:0]       ACK_FLAG  = 8'h04;
  localparam logic [15:0]      SUM_GOOD  = 16'hFFFF;

  typedef enum logic [1:0] {
    VERDICT_ACCEPT       = 2'd0,
    VERDICT_OUT_OF_ORDER = 2'd1,
    VERDICT_BAD          = 2'd2,
    VERDICT_MALFORMED    = 2'd3
  } verdict_t;

  typedef struct packed {
    logic [15:0]      sum;
    logic [31:0]      seq;
    logic [7:0]       flag;
    logic             malformed;
    logic [POS_W-1:0] plen;
  } pkt_info_t;

  // 16-bit one's-complement add with end-around carry
  function automatic logic [15:0] fold(input logic [15:0] sum, input logic [15:0] word);
    logic [16:0] s;
    s = {1'b0, sum} + {1'b0, word};
    return s[16] ? (s[15:0] + 16'd1) : s[15:0];
  endfunction

endpackage

// ===== hdl/swpr_if.sv =====
// Valid/ready channel interfaces for packet bytes and verdict items.
interface swpr_in_if ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface swpr_out_if import swpr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       verdict;
  logic             send_reply;
  logic [31:0]      reply_seq;
  logic [31:0]      reply_ack;
  logic [7:0]       reply_flags;
  logic [POS_W-1:0] payload_length;
  logic             transfer_done;

  modport source (output valid, output verdict, output send_reply, output reply_seq,
                  output reply_ack, output reply_flags, output payload_length,
                  output transfer_done, input ready);
  modport sink   (input valid, input verdict, input send_reply, input reply_seq,
                  input reply_ack, input reply_flags, input payload_length,
                  input transfer_done, output ready);
endinterface

// ===== hdl/swpr_parse.sv =====
// Per-packet parser: checksum fold, seq and flag capture, length check.
module swpr_parse import swpr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output pkt_info_t  info
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      sum_r, sum_nxt;
  logic [7:0]       pend_r, pend_nxt;
  logic [31:0]      seq_r, seq_nxt;
  logic [7:0]       flag_r, flag_nxt;
  logic [15:0]      word;
  logic [15:0]      sum_cur;
  logic [31:0]      seq_cur;
  logic [7:0]       flag_cur;
  logic [POS_W:0]   length;

  always_comb begin
    seq_cur = seq_r;
    if (pos_r < POS_W'(SEQ_BYTES)) begin
      seq_cur[{pos_r[1:0], 3'b000} +: 8] = data_byte;
    end
    flag_cur = (pos_r == POS_W'(FLAG_POS)) ? data_byte : flag_r;
    // odd position completes a pair; an even last byte is padded with zero
    word    = pos_r[0] ? {data_byte, pend_r} : {8'h00, data_byte};
    sum_cur = (pos_r[0] || last_byte) ? fold(sum_r, word) : sum_r;
    length  = {1'b0, pos_r} + (POS_W+1)'(1);

    info.sum       = sum_cur;
    info.seq       = seq_cur;
    info.flag      = flag_cur;
    info.malformed = (length < (POS_W+1)'(HEADER_SIZE)) ||
                     (length > (POS_W+1)'(MAX_PACKET));
    info.plen      = POS_W'(length - (POS_W+1)'(HEADER_SIZE));

    pos_nxt  = pos_r;
    sum_nxt  = sum_r;
    pend_nxt = pend_r;
    seq_nxt  = seq_r;
    flag_nxt = flag_r;
    if (step) begin
      if (last_byte) begin
        pos_nxt  = '0;
        sum_nxt  = '0;
        pend_nxt = '0;
        seq_nxt  = '0;
        flag_nxt = '0;
      end else begin
        pos_nxt  = (pos_r == POS_LIMIT) ? pos_r : pos_r + POS_W'(1);
        sum_nxt  = sum_cur;
        pend_nxt = pos_r[0] ? pend_r : data_byte;
        seq_nxt  = seq_cur;
        flag_nxt = flag_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      sum_r  <= '0;
      pend_r <= '0;
      seq_r  <= '0;
      flag_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      sum_r  <= sum_nxt;
      pend_r <= pend_nxt;
      seq_r  <= seq_nxt;
      flag_r <= flag_nxt;
    end
  end

endmodule

// ===== hdl/stop_and_wait_packet_receiver.sv =====
// Stop-and-wait receiver top level: byte intake, verdict logic, result register, APB.
// Takes one packet byte per cycle and returns one verdict item per packet, once its last
// byte has passed the input register. Each byte passes an input register, a 16-bit
// end-around-carry add plus field capture, and on the last byte the seq compare and the
// 32-bit running-total add and compare, before landing in the result register. A new byte
// is taken every cycle; only a last byte waits, while the result register still holds an
// item not yet taken. transfer_size sits at APB address 0 and should be written while no
// packet is in flight.
`include "stop_and_wait_packet_receiver_assert.svh"

module stop_and_wait_packet_receiver import swpr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  swpr_in_if.sink               in_ch,
  swpr_out_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic             in_valid_r;
  logic [7:0]       in_byte_r;
  logic             in_last_r;
  logic             in_accept;
  logic             out_free;
  logic             proc_fire;
  logic             res_fire;
  pkt_info_t        info;

  logic [31:0]      tsize_r;
  logic [31:0]      last_ack_r, last_ack_nxt;
  logic [31:0]      last_rseq_r, last_rseq_nxt;
  logic [31:0]      total_r, total_nxt;

  verdict_t         res_verdict;
  logic             res_send;
  logic [31:0]      res_seq;
  logic [31:0]      res_ack;
  logic [7:0]       res_flags;
  logic [POS_W-1:0] res_plen;
  logic             res_done;
  logic [31:0]      acc_ack;
  logic [31:0]      acc_rseq;
  logic [31:0]      acc_total;
  logic             in_order;

  logic             out_valid_r;
  verdict_t         out_verdict_r;
  logic             out_send_r;
  logic [31:0]      out_seq_r;
  logic [31:0]      out_ack_r;
  logic [7:0]       out_flags_r;
  logic [POS_W-1:0] out_plen_r;
  logic             out_done_r;

  // intake
  assign out_free     = !out_valid_r || out_ch.ready;
  assign proc_fire    = in_valid_r && (!in_last_r || out_free);
  assign res_fire     = proc_fire && in_last_r;
  assign in_ch.ready  = !in_valid_r || proc_fire;
  assign in_accept    = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_accept) begin
      in_valid_r <= 1'b1;
    end else if (proc_fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_byte_r <= in_ch.data_byte;
      in_last_r <= in_ch.last_byte;
    end
  end

  swpr_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (proc_fire),
    .data_byte (in_byte_r),
    .last_byte (in_last_r),
    .info      (info)
  );

  // verdict
  always_comb begin
    in_order  = (info.seq == last_ack_r + 32'd1);
    acc_ack   = in_order ? info.seq : last_ack_r;
    acc_rseq  = in_order ? info.seq : last_rseq_r;
    acc_total = in_order ? (total_r + 32'(info.plen)) : total_r;

    res_verdict   = VERDICT_MALFORMED;
    res_send      = 1'b0;
    res_seq       = '0;
    res_ack       = '0;
    res_flags     = '0;
    res_plen      = '0;
    res_done      = 1'b0;
    last_ack_nxt  = last_ack_r;
    last_rseq_nxt = last_rseq_r;
    total_nxt     = total_r;

    if (!info.malformed) begin
      res_plen = info.plen;
      if (info.sum == SUM_GOOD && info.flag == ACK_FLAG) begin
        res_verdict   = in_order ? VERDICT_ACCEPT : VERDICT_OUT_OF_ORDER;
        res_send      = 1'b1;
        res_seq       = acc_rseq;
        res_ack       = acc_ack;
        res_flags     = ACK_FLAG;
        res_done      = (acc_total == tsize_r);
        last_rseq_nxt = acc_rseq;
        last_ack_nxt  = res_done ? '0 : acc_ack;
        total_nxt     = res_done ? '0 : acc_total;
      end else begin
        res_verdict = VERDICT_BAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_ack_r  <= '0;
      last_rseq_r <= '0;
      total_r     <= '0;
    end else if (res_fire) begin
      last_ack_r  <= last_ack_nxt;
      last_rseq_r <= last_rseq_nxt;
      total_r     <= total_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      out_verdict_r <= res_verdict;
      out_send_r    <= res_send;
      out_seq_r     <= res_seq;
      out_ack_r     <= res_ack;
      out_flags_r   <= res_flags;
      out_plen_r    <= res_plen;
      out_done_r    <= res_done;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.verdict        = out_verdict_r;
  assign out_ch.send_reply     = out_send_r;
  assign out_ch.reply_seq      = out_seq_r;
  assign out_ch.reply_ack      = out_ack_r;
  assign out_ch.reply_flags    = out_flags_r;
  assign out_ch.payload_length = out_plen_r;
  assign out_ch.transfer_done  = out_done_r;

  // APB register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tsize_r <= '0;
    end else if (psel && penable && pwrite && !paddr[CFG_ADDR_W-1]) begin
      tsize_r <= pwdata;
    end
  end

  assign prdata = tsize_r;
  assign pready = 1'b1;

  `SWPR_ASSERT_NOW(a_reply_only_good, clk, rst_n, out_valid_r && out_send_r,
    out_verdict_r == VERDICT_ACCEPT || out_verdict_r == VERDICT_OUT_OF_ORDER)
  `SWPR_ASSERT_NEXT(a_done_clears, clk, rst_n, res_fire && res_done,
    last_ack_r == 32'd0 && total_r == 32'd0)
  `SWPR_ASSERT_NEXT(a_in_held, clk, rst_n, in_valid_r && !proc_fire,
    in_valid_r && $stable(in_byte_r) && $stable(in_last_r))
  `SWPR_ASSERT_NEXT(a_session_quiet, clk, rst_n, !res_fire,
    $stable(last_ack_r) && $stable(total_r) && $stable(last_rseq_r))

endmodule
